// ===== rtl/sgr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sgr_pkg
// shared types, codes and helpers of the swipe gesture recognizer
// ---------------------------------------------------------------------------
package sgr_pkg;

	localparam int ACC_W     = 24;
	localparam int DELTA_W   = 16;
	localparam int THR_W     = 15;
	localparam int FING_W    = 4;
	localparam int NUM_BIND  = 4;
	localparam int BIDX_W    = 2;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 15;
	localparam int IN_DATA_W = 40;
	localparam int OUT_DATA_W = 8;

	localparam logic [THR_W-1:0] THR_RESET = 15'd2560;

	// event kinds
	localparam logic [1:0] FUNC_BEGIN  = 2'd0;
	localparam logic [1:0] FUNC_UPDATE = 2'd1;
	localparam logic [1:0] FUNC_END    = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BINDING0  = 3'd1;

	// direction codes, bit 1 selects the axis
	localparam logic [1:0] DIR_UP    = 2'd0;
	localparam logic [1:0] DIR_DOWN  = 2'd1;
	localparam logic [1:0] DIR_LEFT  = 2'd2;
	localparam logic [1:0] DIR_RIGHT = 2'd3;

	typedef struct packed {
		logic [FING_W-1:0] fingers;
		logic [1:0]        dir;
		logic              rpt;
		logic              enable;
	} binding_t;

	typedef struct packed {
		logic [THR_W-1:0] threshold;
		binding_t [NUM_BIND-1:0] binding;
	} cfg_t;

	// outcome of one item: which bindings fire and in which sense
	typedef struct packed {
		logic [NUM_BIND-1:0] mask;
		logic                backward;
	} fire_t;

	// saturating accumulate into the signed accumulator range
	function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] acc,
			input logic [DELTA_W-1:0] d);
		logic signed [ACC_W:0] sum;
		sum = $signed({acc[ACC_W-1], acc}) + $signed({{(ACC_W+1-DELTA_W){d[DELTA_W-1]}}, d});
		if (sum[ACC_W] != sum[ACC_W-1]) begin
			return sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
		end
		return sum[ACC_W-1:0];
	endfunction

endpackage
`default_nettype wire

// ===== rtl/swipe_gesture_recognizer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// swipe_gesture_recognizer
// turns touchpad swipe events into per-binding forward/backward actions
// ---------------------------------------------------------------------------
// Events enter on the slave stream, one transfer per event, and land in an
// input register. Once the pending register is free, the gesture state (two
// saturating Q16.8 accumulators, latched finger count, locked direction) is
// updated and the set of firing bindings is parked in a pending register. A
// serializer then sends one action per cycle on the master stream while it is
// ready, lowest binding first, tlast on the final one. An event waits in the
// input register until the pending register is empty or its last action
// moves out, so the next event can be taken while earlier actions still go
// out; events with at most one action pass at one event per cycle while the
// master stream is ready; an event fires at most four actions. Configuration
// writes are always accepted and must only happen while no event is in flight.
// ---------------------------------------------------------------------------
module swipe_gesture_recognizer (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// event stream
	input  wire logic                             s_axis_tvalid,
	output logic                                  s_axis_tready,
	input  wire logic [sgr_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // finger_count, delta_x, delta_y
	input  wire logic [1:0]                       s_axis_tuser,  // func
	// action stream
	output logic                                  m_axis_tvalid,
	input  wire logic                             m_axis_tready,
	output logic [sgr_pkg::OUT_DATA_W-1:0]        m_axis_tdata,  // binding_index
	output logic                                  m_axis_tlast,
	output logic                                  m_axis_tuser,  // backward
	// configuration writes
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [sgr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [sgr_pkg::CFG_DAT_W-1:0]    cfg_data
);
	import sgr_pkg::*;

	// configuration registers
	cfg_t cfg_q;

	// input register
	logic                valid_s1;
	logic [1:0]          func_s1;
	logic [FING_W-1:0]   fing_s1;
	logic [DELTA_W-1:0]  dx_s1, dy_s1;

	// pending actions of the last processed event
	logic [NUM_BIND-1:0] pend_mask_q;
	logic                pend_back_q;

	// output register
	logic                out_valid_q;
	logic [BIDX_W-1:0]   out_idx_q;
	logic                out_back_q;
	logic                out_last_q;

	fire_t               fire;
	logic                in_xfer, out_load, pend_any, pend_one, pend_free, go;
	logic [BIDX_W-1:0]   low_idx;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold <= THR_RESET;
			cfg_q.binding   <= '0;
		end else if (cfg_valid) begin
			if (cfg_index == REG_THRESHOLD) begin
				cfg_q.threshold <= cfg_data[THR_W-1:0];
			end
			for (int i = 0; i < NUM_BIND; i++) begin
				if (cfg_index == CFG_IDX_W'(REG_BINDING0 + i)) begin
					cfg_q.binding[i] <= binding_t'(cfg_data[7:0]);
				end
			end
		end
	end

	// handshake plumbing: pending frees when empty or its last action moves out
	always_comb begin
		out_load  = !out_valid_q || m_axis_tready;
		pend_any  = |pend_mask_q;
		pend_one  = pend_any && ((pend_mask_q & (pend_mask_q - 1'b1)) == '0);
		pend_free = !pend_any || (out_load && pend_one);
		go        = valid_s1 && pend_free;
		in_xfer   = s_axis_tvalid && s_axis_tready;
		low_idx   = '0;
		for (int i = NUM_BIND - 1; i >= 0; i--) begin
			if (pend_mask_q[i]) begin
				low_idx = BIDX_W'(i);
			end
		end
	end

	assign s_axis_tready = !valid_s1 || pend_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			func_s1 <= s_axis_tuser;
			fing_s1 <= s_axis_tdata[3:0];
			dx_s1   <= s_axis_tdata[19:4];
			dy_s1   <= s_axis_tdata[35:20];
		end
	end

	sgr_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.go           (go),
		.func         (func_s1),
		.finger_count (fing_s1),
		.delta_x      (dx_s1),
		.delta_y      (dy_s1),
		.cfg          (cfg_q),
		.fire         (fire)
	);

	// pending mask and output register, one action per transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_mask_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (go) begin
				pend_mask_q <= fire.mask;
			end else if (out_load && pend_any) begin
				pend_mask_q <= pend_mask_q & (pend_mask_q - 1'b1);
			end
			if (out_load) begin
				out_valid_q <= pend_any;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			pend_back_q <= fire.backward;
		end
		if (out_load && pend_any) begin
			out_idx_q  <= low_idx;
			out_back_q <= pend_back_q;
			out_last_q <= pend_one;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_DATA_W-BIDX_W){1'b0}}, out_idx_q};
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tuser  = out_back_q;

endmodule
`default_nettype wire

// ===== rtl/sgr_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sgr_core
// gesture state and the per-event step, lock and binding match
// ---------------------------------------------------------------------------
module sgr_core (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       go,
	input  wire logic [1:0]                 func,
	input  wire logic [sgr_pkg::FING_W-1:0] finger_count,
	input  wire logic [sgr_pkg::DELTA_W-1:0] delta_x,
	input  wire logic [sgr_pkg::DELTA_W-1:0] delta_y,
	input  wire sgr_pkg::cfg_t              cfg,
	output sgr_pkg::fire_t                  fire
);
	import sgr_pkg::*;

	logic [ACC_W-1:0]  acc_x_q, acc_y_q;
	logic [FING_W-1:0] lock_fing_q;
	logic              lock_set_q;
	logic [1:0]        lock_dir_q;

	logic [ACC_W-1:0]  sx, sy, nx, ny;
	logic signed [ACC_W:0] thr_p, thr_n, sx_e, sy_e;
	logic              stepped;
	logic [1:0]        step;
	logic              keep, repeating;
	logic [1:0]        lock;

	always_comb begin
		sx    = sat_add(acc_x_q, delta_x);
		sy    = sat_add(acc_y_q, delta_y);
		sx_e  = $signed({sx[ACC_W-1], sx});
		sy_e  = $signed({sy[ACC_W-1], sy});
		thr_p = $signed({{(ACC_W+1-THR_W){1'b0}}, cfg.threshold});
		thr_n = -thr_p;
		nx      = sx;
		ny      = sy;
		stepped = 1'b1;
		step    = DIR_RIGHT;
		priority if (sx_e > thr_p) begin
			step = DIR_RIGHT;
			nx   = ACC_W'(sx_e - thr_p);
		end else if (sx_e < thr_n) begin
			step = DIR_LEFT;
			nx   = ACC_W'(sx_e + thr_p);
		end else if (sy_e > thr_p) begin
			step = DIR_DOWN;
			ny   = ACC_W'(sy_e - thr_p);
		end else if (sy_e < thr_n) begin
			step = DIR_UP;
			ny   = ACC_W'(sy_e + thr_p);
		end else begin
			stepped = 1'b0;
		end

		// first step locks, same axis repeats, other axis is dropped
		repeating = lock_set_q;
		keep      = stepped && (!lock_set_q || (step[1] == lock_dir_q[1]));
		lock      = lock_set_q ? lock_dir_q : step;

		fire.backward = (step != lock);
		for (int i = 0; i < NUM_BIND; i++) begin
			fire.mask[i] = (func == FUNC_UPDATE) && keep && cfg.binding[i].enable
				&& (!repeating || cfg.binding[i].rpt)
				&& (cfg.binding[i].dir == lock)
				&& (cfg.binding[i].fingers == lock_fing_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_x_q     <= '0;
			acc_y_q     <= '0;
			lock_fing_q <= '0;
			lock_set_q  <= 1'b0;
			lock_dir_q  <= DIR_UP;
		end else if (go) begin
			if (func == FUNC_BEGIN) begin
				acc_x_q     <= '0;
				acc_y_q     <= '0;
				lock_fing_q <= finger_count;
				lock_set_q  <= 1'b0;
				lock_dir_q  <= DIR_UP;
			end else if (func == FUNC_UPDATE) begin
				acc_x_q <= nx;
				acc_y_q <= ny;
				if (stepped && !lock_set_q) begin
					lock_set_q <= 1'b1;
					lock_dir_q <= step;
				end
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/sgr_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sgr_checker
// port-level checks of the swipe gesture recognizer, bound to the top level
// ---------------------------------------------------------------------------
module sgr_checker (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             s_axis_tvalid,
	input wire logic                             s_axis_tready,
	input wire logic [sgr_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	input wire logic [1:0]                       s_axis_tuser,
	input wire logic                             m_axis_tvalid,
	input wire logic                             m_axis_tready,
	input wire logic [sgr_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
	input wire logic                             m_axis_tlast,
	input wire logic                             m_axis_tuser
);
	import sgr_pkg::*;

	// offered event waits unchanged until taken
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && !s_axis_tready |=> s_axis_tvalid
			&& $stable(s_axis_tdata) && $stable(s_axis_tuser))
		else $error("event changed while waiting");

	// stalled action stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid
			&& $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser))
		else $error("action changed while stalled");

	// actions of one event go out without gaps
	a_burst_dense: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
		else $error("gap inside an action burst");

	// within a burst binding indexes rise
	a_burst_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast
			|=> m_axis_tdata[BIDX_W-1:0] > $past(m_axis_tdata[BIDX_W-1:0]))
		else $error("binding order broken in burst");

	// padding bits stay zero
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[OUT_DATA_W-1:BIDX_W] == '0)
		else $error("nonzero padding on action data");

endmodule

bind swipe_gesture_recognizer sgr_checker u_sgr_checker (.*);
`default_nettype wire

// ===== tb/tb_swipe_gesture_recognizer.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_swipe_gesture_recognizer
// self-checking bench for the swipe gesture recognizer
// ---------------------------------------------------------------------------
// A queue of swipe events feeds a clocked stream driver. Every accepted event
// goes through a local gesture tracker that keeps its own accumulators,
// latched finger count, locked direction and register copies, and appends the
// actions it predicts to a queue. A clocked monitor pops that queue on every
// action transfer and compares index, direction sense and end marker. The
// run walks through a directed part, several random register settings, most with
// random gaps on both streams, a long receiver hold-off, a sender pause, and
// a long gesture that drives both accumulators into saturation.
// ---------------------------------------------------------------------------
module tb_swipe_gesture_recognizer;
	import sgr_pkg::*;

	localparam int HALF_PERIOD    = 6;
	localparam int RESET_CYCLES   = 7;
	localparam int HOLD_CYCLES    = 150;
	localparam int DRAIN_CYCLES   = 8;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int MAX_REPORTS    = 10;
	localparam int ACC_HI         = 8388607;
	localparam int ACC_LO         = -8388608;
	localparam int DELTA_HI       = 32767;
	localparam int DELTA_LO       = -32768;
	localparam int THR_HI         = 32767;

	typedef struct {
		logic [1:0]                func;
		logic [FING_W-1:0]         fingers;
		logic signed [DELTA_W-1:0] dx;
		logic signed [DELTA_W-1:0] dy;
	} swipe_event_t;

	typedef struct {
		logic [BIDX_W-1:0] index;
		logic              backward;
		logic              last;
	} action_t;

	// clock and reset
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	// event stream, driven by the bench
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [IN_DATA_W-1:0] s_axis_tdata  = '0;  // finger_count, delta_x, delta_y
	logic [1:0]           s_axis_tuser  = '0;  // func

	// action stream, sampled by the bench
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;   // binding_index
	logic                  m_axis_tlast;
	logic                  m_axis_tuser;   // backward

	// register writes
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DAT_W-1:0] cfg_data  = '0;

	// stimulus and expectations
	swipe_event_t pending_events[$];
	action_t      expected_actions[$];
	swipe_event_t cur_event;
	int           action_errors = 0;
	int           quiet_cycles  = 0;

	// idling control, set from the sequence below
	bit tx_gaps_on  = 1'b0;
	bit rx_gaps_on  = 1'b0;
	int hold_token  = 0;
	int hold_seen   = 0;
	int hold_left   = 0;
	int tx_gap      = 0;
	int rx_gap      = 0;

	// gesture tracker state and register copies
	int              acc_x = 0;
	int              acc_y = 0;
	logic [FING_W-1:0] held_fingers = '0;
	logic [2:0]      held_dir = 3'd0;    // 0 none, else direction code plus one
	int              thr_model = int'(THR_RESET);
	binding_t        bind_model[NUM_BIND];

	swipe_gesture_recognizer i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #HALF_PERIOD clk = ~clk;

	// mostly short gaps, a few long ones
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic int clamp_acc(input int v);
		if (v > ACC_HI)
			return ACC_HI;
		if (v < ACC_LO)
			return ACC_LO;
		return v;
	endfunction

	// gesture tracker: updates the local state for one accepted event and
	// queues the actions it fires
	task automatic recognize_swipe(input swipe_event_t ev);
		int         nx;
		int         ny;
		int         n;
		bit         moved;
		bit         rep_step;
		logic [1:0] step_dir;
		logic [1:0] lock_dir;
		binding_t   b;
		action_t    act;
		if (ev.func == FUNC_BEGIN) begin
			acc_x        = 0;
			acc_y        = 0;
			held_fingers = ev.fingers;
			held_dir     = 3'd0;
			return;
		end
		// end events and the unused kind leave everything alone
		if (ev.func != FUNC_UPDATE)
			return;
		nx       = clamp_acc(acc_x + int'(ev.dx));
		ny       = clamp_acc(acc_y + int'(ev.dy));
		moved    = 1'b1;
		step_dir = DIR_UP;
		// fixed test order: right, left, down, up
		if (nx > thr_model) begin
			step_dir = DIR_RIGHT;
			nx       = nx - thr_model;
		end else if (nx < -thr_model) begin
			step_dir = DIR_LEFT;
			nx       = nx + thr_model;
		end else if (ny > thr_model) begin
			step_dir = DIR_DOWN;
			ny       = ny - thr_model;
		end else if (ny < -thr_model) begin
			step_dir = DIR_UP;
			ny       = ny + thr_model;
		end else begin
			moved = 1'b0;
		end
		acc_x = nx;
		acc_y = ny;
		if (!moved)
			return;
		if (held_dir == 3'd0) begin
			held_dir = {1'b0, step_dir} + 3'd1;
			rep_step = 1'b0;
		end else begin
			lock_dir = 2'(held_dir - 3'd1);
			// bit 1 of a direction code names the axis, other axis is dropped
			if (step_dir[1] != lock_dir[1])
				return;
			rep_step = 1'b1;
		end
		lock_dir = 2'(held_dir - 3'd1);
		n = 0;
		for (int i = 0; i < NUM_BIND; i++) begin
			b = bind_model[i];
			if (!b.enable || (rep_step && !b.rpt))
				continue;
			if (b.dir != lock_dir || b.fingers != held_fingers)
				continue;
			act.index    = BIDX_W'(i);
			act.backward = (step_dir != lock_dir);
			act.last     = 1'b0;
			expected_actions.push_back(act);
			n++;
		end
		if (n > 0)
			expected_actions[expected_actions.size() - 1].last = 1'b1;
	endtask

	// event driver: presents queued events, random gaps between transfers
	always @(posedge clk) begin : event_driver
		bit busy;
		if (arst_n) begin
			busy = s_axis_tvalid;
			if (s_axis_tvalid && s_axis_tready) begin
				recognize_swipe(cur_event);
				busy = 1'b0;
				if (tx_gaps_on && $urandom_range(0, 2) == 0)
					tx_gap = gap_len();
			end
			if (!busy) begin
				if (tx_gap > 0) begin
					tx_gap--;
				end else if (pending_events.size() > 0) begin
					cur_event    = pending_events.pop_front();
					s_axis_tdata <= {{(IN_DATA_W - FING_W - 2 * DELTA_W){1'b0}},
						cur_event.dy, cur_event.dx, cur_event.fingers};
					s_axis_tuser <= cur_event.func;
					busy = 1'b1;
				end
			end
			s_axis_tvalid <= busy;
		end
	end

	// action monitor: checks every transfer against the oldest expectation
	always @(posedge clk) begin : action_monitor
		action_t want;
		bit      rdy;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_actions.size() == 0) begin
					action_errors++;
					if (action_errors <= MAX_REPORTS)
						$display("unexpected action: tdata %h tuser %b tlast %b",
							m_axis_tdata, m_axis_tuser, m_axis_tlast);
				end else begin
					want = expected_actions.pop_front();
					if (m_axis_tdata !== {{(OUT_DATA_W - BIDX_W){1'b0}}, want.index} ||
							m_axis_tuser !== want.backward || m_axis_tlast !== want.last) begin
						action_errors++;
						if (action_errors <= MAX_REPORTS)
							$display("action mismatch: expected index %0d backward %0d last %0d, got tdata %h tuser %b tlast %b",
								want.index, want.backward, want.last,
								m_axis_tdata, m_axis_tuser, m_axis_tlast);
					end
				end
			end
			// long hold-off on request, otherwise random back-pressure
			if (hold_token != hold_seen) begin
				hold_seen = hold_token;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rdy = 1'b0;
			end else if (rx_gap > 0) begin
				rx_gap--;
				rdy = 1'b0;
			end else if (rx_gaps_on && $urandom_range(0, 3) == 0) begin
				rx_gap = gap_len() - 1;
				rdy = 1'b0;
			end else begin
				rdy = 1'b1;
			end
			m_axis_tready <= rdy;
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
					(cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles", quiet_cycles);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	// wait until every event went in and every action came out
	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_events.size() != 0 || s_axis_tvalid || expected_actions.size() != 0);
		// events without actions may still be in the pipeline
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_DAT_W'(value);
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_THRESHOLD)
			thr_model = value & 32'h7fff;
		else
			bind_model[idx - REG_BINDING0] = binding_t'(value[7:0]);
	endtask

	// threshold and all four bindings, then back to a quiet point
	task automatic apply_config(input int thr, input binding_t b0, input binding_t b1,
			input binding_t b2, input binding_t b3);
		write_reg(REG_THRESHOLD, thr);
		write_reg(REG_BINDING0,            int'(b0));
		write_reg(REG_BINDING0 + 3'd1,     int'(b1));
		write_reg(REG_BINDING0 + 3'd2,     int'(b2));
		write_reg(REG_BINDING0 + 3'd3,     int'(b3));
		@(negedge clk);
	endtask

	function automatic binding_t make_binding(input bit en, input bit rpt,
			input logic [1:0] dir, input logic [FING_W-1:0] fingers);
		binding_t b;
		b.enable  = en;
		b.rpt     = rpt;
		b.dir     = dir;
		b.fingers = fingers;
		return b;
	endfunction

	function automatic binding_t random_binding();
		logic [FING_W-1:0] f;
		f = ($urandom_range(0, 9) == 0) ? FING_W'($urandom_range(0, 15))
			: FING_W'($urandom_range(2, 4));
		return make_binding($urandom_range(0, 6) != 0, 1'($urandom_range(0, 1)),
			2'($urandom_range(0, 3)), f);
	endfunction

	task automatic push_event(input logic [1:0] func, input int fingers,
			input int dx, input int dy);
		swipe_event_t ev;
		ev.func    = func;
		ev.fingers = FING_W'(fingers);
		ev.dx      = DELTA_W'(dx);
		ev.dy      = DELTA_W'(dy);
		pending_events.push_back(ev);
	endtask

	// any kind, any field value
	task automatic push_noise();
		push_event(2'($urandom_range(0, 3)), $urandom_range(0, 15),
			$urandom_range(0, 65535), $urandom_range(0, 65535));
	endtask

	// well-formed gesture: begin, updates mostly along one direction, usually an end
	task automatic push_gesture(input int n_updates);
		int         fingers;
		int         mag;
		int         v;
		int         w;
		int         dx;
		int         dy;
		int         r;
		logic [1:0] main_dir;
		logic [1:0] d;
		fingers = ($urandom_range(0, 3) != 0) ? int'(bind_model[$urandom_range(0, 3)].fingers)
			: $urandom_range(0, 15);
		push_event(FUNC_BEGIN, fingers, $urandom_range(0, 65535), $urandom_range(0, 65535));
		main_dir = 2'($urandom_range(0, 3));
		mag = thr_model + thr_model / 2 + 1;
		if (mag > DELTA_HI)
			mag = DELTA_HI;
		for (int k = 0; k < n_updates; k++) begin
			r = $urandom_range(0, 9);
			if (r == 9) begin
				push_event(FUNC_UPDATE, $urandom_range(0, 15),
					$urandom_range(0, 65535), $urandom_range(0, 65535));
				continue;
			end
			// mostly the main direction, sometimes back or across
			d = (r < 7) ? main_dir : (r == 7) ? (main_dir ^ 2'd1) : (main_dir ^ 2'd2);
			v = $urandom_range(0, mag);
			w = $urandom_range(0, mag / 4);
			if ($urandom_range(0, 1))
				w = -w;
			dx = w;
			dy = w;
			case (d)
				DIR_RIGHT: dx = v;
				DIR_LEFT:  dx = -v;
				DIR_DOWN:  dy = v;
				default:   dy = -v;
			endcase
			push_event(FUNC_UPDATE, $urandom_range(0, 15), dx, dy);
		end
		if ($urandom_range(0, 4) != 0)
			push_event(FUNC_END, $urandom_range(0, 15),
				$urandom_range(0, 65535), $urandom_range(0, 65535));
	endtask

	// test sequence
	initial begin : sequencer
		int       thr;
		int       made;
		int       n;
		bit       paused;
		binding_t bw[NUM_BIND];
		for (int i = 0; i < NUM_BIND; i++)
			bind_model[i] = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// update without begin on the reset state and reset registers
		push_event(FUNC_UPDATE, 0, 3000, 0);
		push_event(FUNC_END, 15, 0, 0);
		wait_drained();

		// directed: four bindings on a three finger right swipe
		apply_config(256, make_binding(1'b1, 1'b0, DIR_RIGHT, 4'd3),
			make_binding(1'b1, 1'b1, DIR_RIGHT, 4'd3),
			make_binding(1'b1, 1'b1, DIR_RIGHT, 4'd3),
			make_binding(1'b1, 1'b1, DIR_RIGHT, 4'd3));
		tx_gaps_on <= 1'b1;
		rx_gaps_on <= 1'b1;
		push_event(FUNC_BEGIN, 3, 0, 0);
		push_event(FUNC_UPDATE, 0, DELTA_HI, 0);          // first step, all four fire
		push_event(FUNC_UPDATE, 0, DELTA_LO, 0);          // opposite step, backward repeats
		push_event(FUNC_UPDATE, 0, 0, DELTA_HI);          // across the locked axis
		push_event(FUNC_UPDATE, 0, 0, 0);                 // still across, dropped
		push_event(2'd3, 15, DELTA_LO, DELTA_HI);         // unused kind
		push_event(FUNC_END, 0, DELTA_HI, DELTA_LO);
		push_event(FUNC_UPDATE, 0, 0, DELTA_LO);          // still locked to the x axis
		push_event(FUNC_BEGIN, 2, 0, 0);                  // no binding for two fingers
		push_event(FUNC_UPDATE, 0, 1000, 0);
		push_event(FUNC_BEGIN, 3, 0, 0);
		push_event(FUNC_UPDATE, 0, 0, DELTA_LO);          // locks up, bindings want right
		push_event(FUNC_BEGIN, 15, DELTA_HI, DELTA_HI);
		push_event(FUNC_BEGIN, 0, DELTA_LO, DELTA_LO);
		push_event(FUNC_UPDATE, 15, 300, 0);
		wait_drained();

		// threshold zero: any nonzero accumulator keeps stepping
		write_reg(REG_THRESHOLD, 0);
		@(negedge clk);
		push_event(FUNC_BEGIN, 3, 0, 0);
		push_event(FUNC_UPDATE, 0, 1, 0);
		push_event(FUNC_UPDATE, 0, 0, 0);
		push_event(FUNC_UPDATE, 0, -2, 0);
		push_event(FUNC_UPDATE, 0, 1, 0);
		wait_drained();

		// random settings: phase 0 without idling, phase 2 with a long
		// receiver hold-off, phase 3 with a sender pause in the middle
		for (int ph = 0; ph < 6; ph++) begin
			thr = (ph == 1) ? THR_HI : (ph == 4) ? 1 :
				($urandom_range(0, 2) == 0) ? $urandom_range(1, THR_HI) : $urandom_range(16, 4096);
			for (int i = 0; i < NUM_BIND; i++)
				bw[i] = random_binding();
			if ($urandom_range(0, 2) == 0) begin
				// same direction and finger count everywhere for up to four actions
				for (int i = 1; i < NUM_BIND; i++) begin
					bw[i].dir     = bw[0].dir;
					bw[i].fingers = bw[0].fingers;
				end
			end
			apply_config(thr, bw[0], bw[1], bw[2], bw[3]);
			tx_gaps_on <= (ph != 0) && (ph != 2);
			rx_gaps_on <= (ph != 0);
			made   = 0;
			paused = 1'b0;
			while (made < 10) begin
				if ($urandom_range(0, 4) == 0) begin
					push_noise();
					made++;
				end else begin
					n = $urandom_range(2, 9);
					push_gesture(n);
					made += n + 2;
				end
				if (ph == 3 && !paused && made >= 5) begin
					wait_drained();
					paused = 1'b1;
				end
			end
			if (ph == 2)
				hold_token <= hold_token + 1;
			wait_drained();
		end

		// long gesture with near-limit deltas: y saturates low, x saturates high
		apply_config(1, make_binding(1'b1, 1'b0, DIR_RIGHT, 4'd3),
			make_binding(1'b1, 1'b1, DIR_RIGHT, 4'd3),
			make_binding(1'b1, 1'b1, DIR_RIGHT, 4'd3),
			make_binding(1'b1, 1'b1, DIR_RIGHT, 4'd3));
		tx_gaps_on <= 1'b1;
		rx_gaps_on <= 1'b1;
		push_event(FUNC_BEGIN, 3, 0, 0);
		for (int k = 0; k < 262; k++)
			push_event(FUNC_UPDATE, 0, DELTA_HI - $urandom_range(0, 7),
				DELTA_LO + $urandom_range(0, 7));
		for (int k = 0; k < 4; k++)
			push_event(FUNC_UPDATE, 0, DELTA_LO, DELTA_HI);
		push_event(FUNC_END, 3, 0, 0);
		wait_drained();

		if (action_errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== swipe_gesture_recognizer.f =====
rtl/sgr_pkg.sv
rtl/sgr_core.sv
rtl/swipe_gesture_recognizer.sv
rtl/sgr_checker.sv
tb/tb_swipe_gesture_recognizer.sv
